/* rtl/ntv_pkg.sv */
// shared types, character codes and helper functions of the numeric token validator
package ntv_pkg;

   // token classes carried on the mode field
   localparam logic [2:0] MODE_UINT   = 3'd0;
   localparam logic [2:0] MODE_INT    = 3'd1;
   localparam logic [2:0] MODE_HEX    = 3'd2;
   localparam logic [2:0] MODE_FLOAT  = 3'd3;
   localparam logic [2:0] MODE_TUPLE  = 3'd4;
   localparam logic [2:0] MODE_MATRIX = 3'd5;

   // character codes
   localparam logic [7:0] CH_X      = 8'h78;  // 'x'
   localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] CH_DOT    = 8'h2e;  // '.'
   localparam logic [7:0] CH_COMMA  = 8'h2c;  // ','
   localparam logic [7:0] CH_CLOSE  = 8'h5d;  // ']'
   localparam logic [7:0] CH_OPEN   = 8'h5b;  // '['
   localparam logic [7:0] CH_PLUS   = 8'h2b;  // '+'
   localparam logic [7:0] CH_MINUS  = 8'h2d;  // '-'

   // float scanner phases
   localparam logic [1:0] FP_START = 2'd0;  // expecting sign or first character
   localparam logic [1:0] FP_SIGN  = 2'd1;  // after sign
   localparam logic [1:0] FP_NEED  = 2'd2;  // a digit is required
   localparam logic [1:0] FP_BODY  = 2'd3;  // in digits

   // float scanner verdicts
   localparam logic [1:0] FR_OK   = 2'd0;
   localparam logic [1:0] FR_ERR  = 2'd1;
   localparam logic [1:0] FR_TERM = 2'd2;

   // last tuple index per tuple class
   localparam logic [1:0] LAST_TUPLE_XYZ    = 2'd0;
   localparam logic [1:0] LAST_TUPLE_MATRIX = 2'd2;

   typedef struct packed {
      logic [1:0] char_count;
      logic       error_seen;
      logic       first_was_zero;
      logic       hex_body;
      logic [1:0] float_phase;
      logic       dot_seen;
      logic [1:0] tuple_field;
      logic [1:0] tuple_number;
      logic       tuple_phase;
      logic       finished;
   } ntv_state_type;

   localparam ntv_state_type STATE_RESET = '0;

   typedef struct packed {
      logic [1:0] phase;
      logic       dot;
      logic [1:0] verdict;
   } ntv_float_type;

   typedef struct packed {
      logic status;
      logic complete;
   } ntv_result_type;

   function automatic logic is_dig(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_xdig(logic [7:0] c);
      return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

endpackage

/* rtl/ntv_core.sv */
// token state registers and the per-character update and completion logic
module ntv_core
   import ntv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,   // one character processed this cycle
   input  logic [2:0]     mode,
   input  logic [7:0]     ch,
   input  logic           last,
   output ntv_result_type result      // valid when step_en and last
);

   ntv_state_type state_ff;
   ntv_state_type state_in;
   ntv_state_type nxt;
   ntv_float_type fr;
   logic [7:0]    term;
   logic          has_term;
   logic [1:0]    last_tuple;
   logic          comp;

   // float scanner, shared by the float class and tuple fields
   function automatic ntv_float_type float_step(logic [1:0] phase, logic dot,
                                                logic [7:0] c, logic use_term,
                                                logic [7:0] tc);
      ntv_float_type r;
      r.phase   = phase;
      r.dot     = dot;
      r.verdict = FR_OK;
      if (phase == FP_START && (c == CH_PLUS || c == CH_MINUS)) begin
         r.phase = FP_SIGN;
      end else if (phase == FP_START || phase == FP_SIGN) begin
         if (c == CH_DOT) begin
            r.dot   = 1'b1;
            r.phase = FP_NEED;
         end else if (is_dig(c)) begin
            r.phase = FP_BODY;
         end else begin
            r.verdict = FR_ERR;
         end
      end else if (phase == FP_NEED) begin
         if (is_dig(c)) begin
            r.phase = FP_BODY;
         end else begin
            r.verdict = FR_ERR;
         end
      end else if (use_term && c == tc) begin
         r.verdict = FR_TERM;
      end else if (c == CH_DOT) begin
         if (dot) begin
            r.verdict = FR_ERR;
         end else begin
            r.dot   = 1'b1;
            r.phase = FP_NEED;
         end
      end else if (!is_dig(c)) begin
         r.verdict = FR_ERR;
      end
      return r;
   endfunction

   always_comb begin
      has_term   = (mode == MODE_TUPLE) || (mode == MODE_MATRIX);
      term       = (state_ff.tuple_field < 2'd2) ? CH_COMMA : CH_CLOSE;
      last_tuple = (mode == MODE_MATRIX) ? LAST_TUPLE_MATRIX : LAST_TUPLE_XYZ;
      fr         = float_step(state_ff.float_phase, state_ff.dot_seen, ch, has_term, term);
      nxt        = state_ff;

      if (!state_ff.error_seen && !state_ff.finished) begin
         unique case (mode)
            MODE_UINT: begin
               if (state_ff.char_count == 2'd0) begin
                  if (!is_dig(ch)) nxt.error_seen = 1'b1;
                  nxt.first_was_zero = (ch == CH_ZERO);
               end else if (state_ff.char_count == 2'd1) begin
                  if (ch == CH_X) begin
                     if (state_ff.first_was_zero) nxt.hex_body = 1'b1;
                     else nxt.error_seen = 1'b1;
                  end else if (!is_dig(ch)) begin
                     nxt.error_seen = 1'b1;
                  end
               end else if (!(state_ff.hex_body ? is_xdig(ch) : is_dig(ch))) begin
                  nxt.error_seen = 1'b1;
               end
            end
            MODE_INT: begin
               if (state_ff.char_count == 2'd0) begin
                  if (!is_dig(ch) && ch != CH_PLUS && ch != CH_MINUS) nxt.error_seen = 1'b1;
               end else if (!is_dig(ch)) begin
                  nxt.error_seen = 1'b1;
               end
            end
            MODE_HEX: begin
               if (state_ff.char_count == 2'd0) begin
                  if (ch != CH_ZERO) nxt.error_seen = 1'b1;
               end else if (state_ff.char_count == 2'd1) begin
                  if (ch != CH_X) nxt.error_seen = 1'b1;
               end else if (!is_xdig(ch)) begin
                  nxt.error_seen = 1'b1;
               end
            end
            MODE_FLOAT: begin
               if (fr.verdict == FR_ERR) begin
                  nxt.error_seen = 1'b1;
               end else begin
                  nxt.float_phase = fr.phase;
                  nxt.dot_seen    = fr.dot;
               end
            end
            MODE_TUPLE, MODE_MATRIX: begin
               if (!state_ff.tuple_phase) begin
                  if (ch == CH_OPEN) begin
                     nxt.tuple_phase = 1'b1;
                     nxt.tuple_field = 2'd0;
                     nxt.float_phase = FP_START;
                     nxt.dot_seen    = 1'b0;
                  end else begin
                     nxt.error_seen = 1'b1;
                  end
               end else if (fr.verdict == FR_ERR) begin
                  nxt.error_seen = 1'b1;
               end else if (fr.verdict == FR_TERM) begin
                  // separator or closing bracket ends the current float
                  if (state_ff.tuple_field < 2'd2) begin
                     nxt.tuple_field = state_ff.tuple_field + 2'd1;
                     nxt.float_phase = FP_START;
                     nxt.dot_seen    = 1'b0;
                  end else if (state_ff.tuple_number >= last_tuple) begin
                     nxt.finished = 1'b1;
                  end else begin
                     nxt.tuple_number = state_ff.tuple_number + 2'd1;
                     nxt.tuple_phase  = 1'b0;
                  end
               end else begin
                  nxt.float_phase = fr.phase;
                  nxt.dot_seen    = fr.dot;
               end
            end
            default: nxt.error_seen = 1'b1;
         endcase
      end

      if (state_ff.char_count != 2'd3) nxt.char_count = state_ff.char_count + 2'd1;

      comp = 1'b0;
      if (!nxt.error_seen) begin
         unique case (mode)
            MODE_UINT:   comp = !(nxt.hex_body && state_ff.char_count == 2'd1);
            MODE_INT:    comp = !(state_ff.char_count == 2'd0 &&
                                  (ch == CH_PLUS || ch == CH_MINUS));
            MODE_HEX:    comp = (state_ff.char_count >= 2'd2);
            MODE_FLOAT:  comp = 1'b1;
            MODE_TUPLE, MODE_MATRIX: comp = nxt.finished;
            default:     comp = 1'b0;
         endcase
      end
      result.status   = nxt.error_seen;
      result.complete = comp;

      if (!step_en) state_in = state_ff;
      else if (last) state_in = STATE_RESET;
      else state_in = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/numeric_token_validator_top.sv */
// top level of the numeric token validator: input register, token core, result register
//
// Checks a numeric token one character per transfer against the class given on
// req_tuser (0 unsigned decimal or 0x-hex, 1 signed decimal, 2 0x-hex, 3 float,
// 4 [f,f,f] tuple, 5 matrix of three tuples; 6 and 7 reject everything). No result
// leaves while the token goes on; on the character marked by req_tlast one result
// transfer gives status (0 valid prefix, 1 unexpected character) and complete, and
// the running state returns to its reset value. After the closing bracket of the
// last tuple further characters are ignored; after an error the rest of the token
// is ignored. One character is taken every cycle while nothing stalls; a result is
// offered on rsp_tvalid after its last character has passed through the input
// register and, by way of the state update in the token core, into the result
// register. The only stall is a held result register with rsp_tready low when a
// last character reaches the core.
module numeric_token_validator_top
   import ntv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // character stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] ch
   input  logic [2:0] req_tuser,    // [2:0] mode
   input  logic       req_tlast,    // last character of the token
   // verdict stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [0] status, [1] complete, [7:2] zero
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic [2:0] in_mode_ff;
   logic       in_last_ff;

   // result register
   logic           out_valid_ff, out_valid_in;
   ntv_result_type out_res_ff, out_res_in;

   ntv_result_type core_res;
   logic           step_en;
   logic           req_fire;

   // the held character moves on unless it would produce a result that has
   // nowhere to go
   assign step_en    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_fire   = req_tvalid && req_tready;

   ntv_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .mode    (in_mode_ff),
      .ch      (in_ch_ff),
      .last    (in_last_ff),
      .result  (core_res)
   );

   always_comb begin
      in_valid_in = req_fire || (in_valid_ff && !step_en);

      out_valid_in = out_valid_ff && !rsp_tready;
      out_res_in   = out_res_ff;
      if (step_en && in_last_ff) begin
         out_valid_in = 1'b1;
         out_res_in   = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff   <= req_tdata;
         in_mode_ff <= req_tuser;
         in_last_ff <= req_tlast;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_res_ff.complete, out_res_ff.status};

endmodule
